// File: src/char_lcd_nibble_sequencer_assert.svh
// assertion macros for the lcd nibble sequencer rtl
`ifndef CHAR_LCD_NIBBLE_SEQUENCER_ASSERT_SVH
`define CHAR_LCD_NIBBLE_SEQUENCER_ASSERT_SVH

`ifndef ASSERT_OFF
`define CLNS_ASSERT_NEVER(label, clk, rst, expr) \
  label: assert property (@(posedge clk) disable iff (rst) !(expr)) \
    else $error("clns assertion failed");
`define CLNS_ASSERT_IMPLIES(label, clk, rst, cond, conseq) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (conseq)) \
    else $error("clns assertion failed");
`else
`define CLNS_ASSERT_NEVER(label, clk, rst, expr)
`define CLNS_ASSERT_IMPLIES(label, clk, rst, cond, conseq)
`endif

`endif

// File: src/clns_pkg.sv
// types, codes and init tables of the lcd nibble sequencer
`default_nettype none

package clns_pkg;

  // request codes carried in the input tuser
  localparam logic [2:0] REQ_CMD    = 3'd0;
  localparam logic [2:0] REQ_DATA   = 3'd1;
  localparam logic [2:0] REQ_CURSOR = 3'd2;
  localparam logic [2:0] REQ_CLEAR  = 3'd3;
  localparam logic [2:0] REQ_INIT   = 3'd4;

  // configuration register indexes
  localparam logic CFG_PULSE_HOLD = 1'b0;
  localparam logic CFG_CLEAR_WAIT = 1'b1;

  localparam logic [9:0]  PULSE_HOLD_RESET = 10'd20;
  localparam logic [15:0] CLEAR_WAIT_RESET = 16'd2;

  localparam logic [7:0] ROW0_BASE = 8'h80;
  localparam logic [7:0] ROW1_BASE = 8'hC0;
  localparam logic [7:0] CMD_CLEAR = 8'h01;

  localparam logic [3:0] INIT_LAST = 4'd8;

  typedef enum logic [1:0] {
    JOB_BYTE,
    JOB_CLEAR,
    JOB_INIT
  } job_kind_t;

  typedef struct packed {
    job_kind_t  kind;
    logic       rs;
    logic [7:0] byte_val;
  } job_t;

  // sequencer state: idle, the four enable phases of a byte, or a wait
  typedef enum logic [2:0] {
    PH_IDLE,
    PH_HI_ON,
    PH_HI_OFF,
    PH_LO_ON,
    PH_LO_OFF,
    PH_WAIT
  } phase_t;

  function automatic logic [7:0] init_cmd(input logic [3:0] step);
    logic [7:0] c;
    unique case (step)
      4'd0, 4'd1, 4'd2: c = 8'h30;
      4'd3:             c = 8'h20;
      4'd4:             c = 8'h28;
      4'd5:             c = 8'h08;
      4'd6:             c = 8'h01;
      4'd7:             c = 8'h06;
      4'd8:             c = 8'h0C;
      default:          c = 8'h00;
    endcase
    return c;
  endfunction

  // wait that comes before each init command
  function automatic logic [15:0] init_wait(input logic [3:0] step);
    logic [15:0] w;
    unique case (step)
      4'd0:       w = 16'd50000;
      4'd1:       w = 16'd5000;
      4'd2:       w = 16'd1000;
      4'd3, 4'd4: w = 16'd10000;
      4'd5, 4'd6: w = 16'd1000;
      4'd7:       w = 16'd2000;
      4'd8:       w = 16'd1000;
      default:    w = 16'd0;
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// File: src/clns_front.sv
// front end: accepts requests and turns them into byte, clear or init jobs
`default_nettype none

module clns_front import clns_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,
  input  logic [2:0]  s_tuser,
  output logic        job_valid,
  input  logic        job_ready,
  output job_t        job_out
);

  logic       type_ok;
  job_t       job_new;
  logic [7:0] byte_value;
  logic [1:0] cursor_row;
  logic [4:0] cursor_col;
  logic [3:0] col_fixed;

  assign byte_value = s_tdata[7:0];
  assign cursor_row = s_tdata[9:8];
  assign cursor_col = s_tdata[14:10];
  assign col_fixed  = cursor_col[4] ? 4'd0 : cursor_col[3:0];

  assign s_tready = !job_valid || job_ready;

  always_comb begin
    type_ok          = 1'b1;
    job_new.kind     = JOB_BYTE;
    job_new.rs       = 1'b0;
    job_new.byte_val = byte_value;
    unique case (s_tuser)
      REQ_CMD: begin
      end
      REQ_DATA: begin
        job_new.rs = 1'b1;
      end
      REQ_CURSOR: begin
        job_new.byte_val = (cursor_row == 2'd1 ? ROW1_BASE : ROW0_BASE) | {4'd0, col_fixed};
      end
      REQ_CLEAR: begin
        job_new.kind     = JOB_CLEAR;
        job_new.byte_val = CMD_CLEAR;
      end
      REQ_INIT: begin
        job_new.kind = JOB_INIT;
      end
      default: begin
        type_ok = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      job_valid <= 1'b0;
    end else begin
      // unknown request types are taken and dropped
      job_valid <= (s_tvalid && s_tready && type_ok) || (job_valid && !job_ready);
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready && type_ok) begin
      job_out <= job_new;
    end
  end

endmodule

`default_nettype wire

// File: src/clns_queue.sv
// short job queue between the front end and the sequencer
`default_nettype none

module clns_queue import clns_pkg::*; #(
  parameter int DEPTH = 2
) (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  output logic push_ready,
  input  job_t push_job,
  output logic pop_valid,
  input  logic pop,
  output job_t pop_job
);

  localparam int PW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  job_t          mem [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;
  logic          do_push;
  logic          do_pop;

  assign push_ready = count != CW'(DEPTH);
  assign pop_valid  = count != '0;
  assign pop_job    = mem[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_job;
    end
  end

endmodule

`default_nettype wire

// File: src/clns_back.sv
// back end: steps through the pin events of one job into an output register
`default_nettype none

`include "char_lcd_nibble_sequencer_assert.svh"

module clns_back import clns_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic [9:0]  pulse_hold_us,
  input  logic [15:0] clear_wait_us,
  input  logic        job_valid,
  input  job_t        job_in,
  output logic        job_pop,
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,
  output logic        m_tuser,
  output logic        m_tlast
);

  phase_t      state;
  phase_t      state_next;
  logic [3:0]  step;
  logic [3:0]  step_next;
  job_t        job;
  logic        load;
  logic [7:0]  cur_byte;
  logic [7:0]  prev_cmd;
  logic        ev_rs;
  logic [3:0]  ev_nibble;
  logic        ev_en;
  logic [15:0] ev_hold;
  logic        ev_last;

  assign load    = (state != PH_IDLE) && (!m_tvalid || m_tready);
  assign job_pop = (state == PH_IDLE) && job_valid;

  assign cur_byte = (job.kind == JOB_INIT) ? init_cmd(step) : job.byte_val;
  assign prev_cmd = (step == 4'd0) ? 8'h00 : init_cmd(step - 4'd1);

  // event fields of the current state
  always_comb begin
    ev_rs     = job.rs;
    ev_nibble = cur_byte[7:4];
    ev_en     = 1'b1;
    ev_hold   = {6'd0, pulse_hold_us};
    ev_last   = 1'b0;
    unique case (state)
      PH_HI_ON: begin
      end
      PH_HI_OFF: begin
        ev_en = 1'b0;
      end
      PH_LO_ON: begin
        ev_nibble = cur_byte[3:0];
      end
      PH_LO_OFF: begin
        ev_nibble = cur_byte[3:0];
        ev_en     = 1'b0;
        ev_last   = (job.kind == JOB_BYTE) ||
                    (job.kind == JOB_INIT && step == INIT_LAST);
      end
      PH_WAIT: begin
        ev_rs = 1'b0;
        ev_en = 1'b0;
        if (job.kind == JOB_CLEAR) begin
          ev_nibble = CMD_CLEAR[3:0];
          ev_hold   = clear_wait_us;
          ev_last   = 1'b1;
        end else begin
          ev_nibble = prev_cmd[3:0];
          ev_hold   = init_wait(step);
        end
      end
      default: begin
      end
    endcase
  end

  always_comb begin
    state_next = state;
    step_next  = step;
    unique case (state)
      PH_IDLE: begin
        if (job_valid) begin
          state_next = (job_in.kind == JOB_INIT) ? PH_WAIT : PH_HI_ON;
          step_next  = 4'd0;
        end
      end
      PH_HI_ON: begin
        if (load) state_next = PH_HI_OFF;
      end
      PH_HI_OFF: begin
        if (load) state_next = PH_LO_ON;
      end
      PH_LO_ON: begin
        if (load) state_next = PH_LO_OFF;
      end
      PH_LO_OFF: begin
        if (load) begin
          if (job.kind == JOB_CLEAR) begin
            state_next = PH_WAIT;
          end else if (job.kind == JOB_INIT && step != INIT_LAST) begin
            state_next = PH_WAIT;
            step_next  = step + 4'd1;
          end else begin
            state_next = PH_IDLE;
          end
        end
      end
      PH_WAIT: begin
        if (load) state_next = (job.kind == JOB_CLEAR) ? PH_IDLE : PH_HI_ON;
      end
      default: begin
        state_next = PH_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= PH_IDLE;
      step  <= 4'd0;
    end else begin
      state <= state_next;
      step  <= step_next;
    end
  end

  always_ff @(posedge clk) begin
    if (job_pop) begin
      job <= job_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= {3'd0, ev_hold, ev_en, ev_nibble};
      m_tuser <= ev_rs;
      m_tlast <= ev_last;
    end
  end

  `CLNS_ASSERT_NEVER(a_step_range, clk, rst, state != PH_IDLE && step > INIT_LAST)
  `CLNS_ASSERT_NEVER(a_byte_no_wait, clk, rst, state == PH_WAIT && job.kind == JOB_BYTE)
  `CLNS_ASSERT_IMPLIES(a_pop_when_idle, clk, rst, job_pop, state == PH_IDLE && !load)

endmodule

`default_nettype wire

// File: src/char_lcd_nibble_sequencer.sv
// top level of the character lcd 4-bit nibble sequencer
//
// input stream (s_*): one word per request. s_tuser holds the request
// type (command, data, set cursor, clear, initialise); s_tdata holds the
// byte and the cursor position. unknown types are taken and dropped.
// output stream (m_*): one word per pin event, rs in m_tuser, nibble,
// enable level and hold time in m_tdata, m_tlast on a request's final event.
// cfg port: cfg_we writes cfg_data into register cfg_index at the clock
// edge (0 pulse hold, 1 clear wait); write only while the block is idle.
// path: from the edge that takes the request word, the first event of a
// request passes the queue, sequencer and output register on its way to m_*.
// throughput: the sequencer emits one event per cycle while m_tready lets the
// output register take it, and picks up each job in its idle state first;
// the sequencer sets the rate, the queue hides the front.
// reset (rst, synchronous) empties the queue, idles the sequencer and loads
// pulse hold 20 and clear wait 2. when m_tready is low the event in the output
// register holds, the sequencer waits, and requests pile up in the queue
// until s_tready drops.
`default_nettype none

module char_lcd_nibble_sequencer import clns_pkg::*; #(
  parameter int JOB_DEPTH = 2
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [15:0] s_tdata,   // byte_value[7:0], cursor_row[9:8], cursor_col[14:10]
  input  logic [2:0]  s_tuser,   // req_type[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // nibble[3:0], enable_level[4], hold_us[20:5]
  output logic        m_tuser,   // reg_select[0]
  output logic        m_tlast,   // last_event
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data
);

  // configuration registers
  logic [9:0]  pulse_hold_us;
  logic [15:0] clear_wait_us;

  // front to queue, queue to sequencer
  logic job_f_valid;
  logic job_f_ready;
  job_t job_f;
  logic job_q_valid;
  logic job_q_pop;
  job_t job_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      pulse_hold_us <= PULSE_HOLD_RESET;
      clear_wait_us <= CLEAR_WAIT_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PULSE_HOLD: pulse_hold_us <= cfg_data[9:0];
        CFG_CLEAR_WAIT: clear_wait_us <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // classify requests into jobs
  clns_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .job_valid (job_f_valid),
    .job_ready (job_f_ready),
    .job_out   (job_f)
  );

  // decouples request intake from event output
  clns_queue #(
    .DEPTH (JOB_DEPTH)
  ) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (job_f_valid),
    .push_ready (job_f_ready),
    .push_job   (job_f),
    .pop_valid  (job_q_valid),
    .pop        (job_q_pop),
    .pop_job    (job_q)
  );

  // walks each job through its pin events
  clns_back u_back (
    .clk           (clk),
    .rst           (rst),
    .pulse_hold_us (pulse_hold_us),
    .clear_wait_us (clear_wait_us),
    .job_valid     (job_q_valid),
    .job_in        (job_q),
    .job_pop       (job_q_pop),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .m_tuser       (m_tuser),
    .m_tlast       (m_tlast)
  );

endmodule

`default_nettype wire

// File: bench/tb_top.sv
// self-checking bench for the lcd nibble sequencer: directed table, then random phases
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import clns_pkg::*;

  // request codes the block must swallow without any pin event
  localparam logic [2:0] REQ_RSVD_LO = 3'd5;
  localparam logic [2:0] REQ_RSVD_MID = 3'd6;
  localparam logic [2:0] REQ_RSVD_HI = 3'd7;

  localparam int WATCHDOG_LIMIT = 2000;  // quiet cycles before giving up
  localparam int SETTLE_CYCLES = 16;     // longer than the front-to-output latency
  localparam int LONG_HOLD = 200;        // receiver hold-off that backs up the input
  localparam int ITEMS_PER_PHASE = 45;
  localparam int NUM_PHASES = 5;

  // power-up command sequence and the wait in front of each command
  localparam logic [7:0] INIT_SEQ [9] = '{
    8'h30, 8'h30, 8'h30, 8'h20, 8'h28, 8'h08, 8'h01, 8'h06, 8'h0C
  };
  localparam logic [15:0] INIT_GAP_US [9] = '{
    16'd50000, 16'd5000, 16'd1000, 16'd10000, 16'd10000,
    16'd1000, 16'd1000, 16'd2000, 16'd1000
  };

  // idle and stall percentages per random phase
  localparam int SRC_IDLE [NUM_PHASES] = '{0, 53, 0, 30, 0};
  localparam int SNK_STALL [NUM_PHASES] = '{0, 0, 53, 30, 0};

  // one pin event as it leaves the block
  typedef struct packed {
    logic        rs;
    logic [3:0]  nib;
    logic        en;
    logic [15:0] hold;
    logic        last;
  } pin_event_t;

  // directed row: request fields, then an optional typed expectation
  // (four events of t_byte with t_rs and t_hold, or nothing when t_silent)
  typedef struct packed {
    logic [2:0]  req;
    logic [7:0]  byte_v;
    logic [1:0]  row;
    logic [4:0]  col;
    logic        typed;
    logic        t_silent;
    logic        t_rs;
    logic [7:0]  t_byte;
    logic [15:0] t_hold;
  } dir_row_t;

  // directed part, all at the reset register values (pulse hold 20)
  localparam dir_row_t DIR_TAB [17] = '{
    '{REQ_CMD,      8'h00, 2'd0, 5'd0,  1'b1, 1'b0, 1'b0, 8'h00, 16'd20},
    '{REQ_CMD,      8'hFF, 2'd3, 5'd31, 1'b1, 1'b0, 1'b0, 8'hFF, 16'd20},
    '{REQ_DATA,     8'h00, 2'd0, 5'd0,  1'b1, 1'b0, 1'b1, 8'h00, 16'd20},
    '{REQ_DATA,     8'hFF, 2'd0, 5'd0,  1'b1, 1'b0, 1'b1, 8'hFF, 16'd20},
    '{REQ_DATA,     8'hA5, 2'd2, 5'd21, 1'b1, 1'b0, 1'b1, 8'hA5, 16'd20},
    '{REQ_CURSOR,   8'h00, 2'd0, 5'd0,  1'b1, 1'b0, 1'b0, 8'h80, 16'd20},
    '{REQ_CURSOR,   8'hFF, 2'd1, 5'd15, 1'b1, 1'b0, 1'b0, 8'hCF, 16'd20},
    '{REQ_CURSOR,   8'h00, 2'd2, 5'd16, 1'b1, 1'b0, 1'b0, 8'h80, 16'd20},
    '{REQ_CURSOR,   8'h00, 2'd3, 5'd31, 1'b1, 1'b0, 1'b0, 8'h80, 16'd20},
    '{REQ_CURSOR,   8'h00, 2'd1, 5'd31, 1'b1, 1'b0, 1'b0, 8'hC0, 16'd20},
    '{REQ_CLEAR,    8'h00, 2'd0, 5'd0,  1'b0, 1'b0, 1'b0, 8'h00, 16'd0},
    '{REQ_INIT,     8'h00, 2'd0, 5'd0,  1'b0, 1'b0, 1'b0, 8'h00, 16'd0},
    '{REQ_RSVD_LO,  8'hFF, 2'd3, 5'd31, 1'b1, 1'b1, 1'b0, 8'h00, 16'd0},
    '{REQ_RSVD_MID, 8'h00, 2'd0, 5'd0,  1'b1, 1'b1, 1'b0, 8'h00, 16'd0},
    '{REQ_RSVD_HI,  8'h5A, 2'd1, 5'd10, 1'b1, 1'b1, 1'b0, 8'h00, 16'd0},
    '{REQ_CMD,      8'h5A, 2'd1, 5'd10, 1'b0, 1'b0, 1'b0, 8'h00, 16'd0},
    '{REQ_CURSOR,   8'h00, 2'd1, 5'd7,  1'b0, 1'b0, 1'b0, 8'h00, 16'd0}
  };

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [15:0] s_tdata;   // byte_value[7:0], cursor_row[9:8], cursor_col[14:10]
  logic [2:0]  s_tuser;   // req_type[2:0]
  logic        m_tvalid;
  logic        m_tready;
  logic [23:0] m_tdata;   // nibble[3:0], enable_level[4], hold_us[20:5]
  logic        m_tuser;   // reg_select[0]
  logic        m_tlast;   // last_event
  logic        cfg_we;
  logic        cfg_index;
  logic [15:0] cfg_data;

  // predictor copy of the two registers
  logic [9:0]  lcd_pulse_us;
  logic [15:0] lcd_clear_us;

  // pin events still owed by the block, oldest first
  pin_event_t  pin_event_q [$];

  int          mismatches = 0;
  int          events_seen = 0;
  int          src_idle_pct = 0;
  int          snk_stall_pct = 0;
  bit          hold_off_go = 1'b0;

  char_lcd_nibble_sequencer u_top (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .m_tlast   (m_tlast),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------

  task automatic push_pin_event(input logic rs, input logic [3:0] nib, input logic en,
                                input logic [15:0] hold, input logic last);
    pin_event_q.push_back({rs, nib, en, hold, last});
  endtask

  // a byte goes out high nibble first, each nibble as enable high then low
  task automatic push_byte_events(input logic rs, input logic [7:0] b,
                                  input logic [15:0] hold, input logic fin);
    push_pin_event(rs, b[7:4], 1'b1, hold, 1'b0);
    push_pin_event(rs, b[7:4], 1'b0, hold, 1'b0);
    push_pin_event(rs, b[3:0], 1'b1, hold, 1'b0);
    push_pin_event(rs, b[3:0], 1'b0, hold, fin);
  endtask

  task automatic lcd_expand_request(input logic [2:0] req, input logic [7:0] b,
                                    input logic [1:0] row, input logic [4:0] col);
    logic [15:0] pulse;
    logic [7:0]  addr;
    logic [3:0]  prev_lo;
    pulse = {6'd0, lcd_pulse_us};
    case (req)
      REQ_CMD: push_byte_events(1'b0, b, pulse, 1'b1);
      REQ_DATA: push_byte_events(1'b1, b, pulse, 1'b1);
      REQ_CURSOR: begin
        // row 1 is the second line, every other row the first; columns past 15 become 0
        addr = (row == 2'd1) ? ROW1_BASE : ROW0_BASE;
        addr = addr | {4'd0, (col[4] ? 4'd0 : col[3:0])};
        push_byte_events(1'b0, addr, pulse, 1'b1);
      end
      REQ_CLEAR: begin
        // clear command, then a wait that keeps the low nibble on the pins
        push_byte_events(1'b0, CMD_CLEAR, pulse, 1'b0);
        push_pin_event(1'b0, CMD_CLEAR[3:0], 1'b0, lcd_clear_us, 1'b1);
      end
      REQ_INIT: begin
        for (int i = 0; i < 9; i++) begin
          // the opening wait comes before any pin was driven, so its nibble is 0
          prev_lo = (i == 0) ? 4'd0 : INIT_SEQ[i - 1][3:0];
          push_pin_event(1'b0, prev_lo, 1'b0, INIT_GAP_US[i], 1'b0);
          push_byte_events(1'b0, INIT_SEQ[i], pulse, i == 8);
        end
      end
      default: ;  // reserved codes: no events
    endcase
  endtask

  // ---------------------------------------------------------------------------
  // sender side
  // ---------------------------------------------------------------------------

  // offer one request word, with random idle cycles in front, until it is taken;
  // returns in the time step of the accepting edge with s_tvalid still high
  task automatic send_word(input logic [2:0] req, input logic [7:0] b, input logic [1:0] row,
                           input logic [4:0] col, input bit predict);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser <= req;
    s_tdata <= {1'b0, col, row, b};
    do @(posedge clk); while (!s_tready);
    if (predict)
      lcd_expand_request(req, b, row, col);
  endtask

  // drop valid, let every owed event out, then give a possibly dropped word time to clear
  task automatic wait_idle();
    s_tvalid <= 1'b0;
    while (pin_event_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // two back-to-back register writes; the predictor follows at each write edge
  task automatic write_regs(input logic [15:0] pulse_w, input logic [15:0] clear_w);
    cfg_we <= 1'b1;
    cfg_index <= CFG_PULSE_HOLD;
    cfg_data <= pulse_w;
    @(posedge clk);
    lcd_pulse_us = pulse_w[9:0];
    cfg_index <= CFG_CLEAR_WAIT;
    cfg_data <= clear_w;
    @(posedge clk);
    lcd_clear_us = clear_w;
    cfg_we <= 1'b0;
  endtask

  // mostly well-formed requests, with a sprinkling of reserved codes
  function automatic logic [2:0] pick_req();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 25) return REQ_CMD;
    if (r < 55) return REQ_DATA;
    if (r < 75) return REQ_CURSOR;
    if (r < 85) return REQ_CLEAR;
    if (r < 92) return REQ_INIT;
    return 3'($urandom_range(REQ_RSVD_HI, REQ_RSVD_LO));
  endfunction

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------

  initial begin
    dir_row_t    dr;
    logic [2:0]  req;
    logic [15:0] pulse_w;
    logic [15:0] clear_w;
    int          taken;

    rst <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata <= '0;
    s_tuser <= REQ_CMD;
    cfg_we <= 1'b0;
    cfg_index <= CFG_PULSE_HOLD;
    cfg_data <= '0;
    lcd_pulse_us = PULSE_HOLD_RESET;
    lcd_clear_us = CLEAR_WAIT_RESET;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed rows: typed expectation where given, predictor otherwise
    foreach (DIR_TAB[i]) begin
      dr = DIR_TAB[i];
      send_word(dr.req, dr.byte_v, dr.row, dr.col, !dr.typed);
      if (dr.typed && !dr.t_silent)
        push_byte_events(dr.t_rs, dr.t_byte, dr.t_hold, 1'b1);
    end

    // random phases, each with its own register setting and idle pattern
    for (int p = 0; p < NUM_PHASES; p++) begin
      wait_idle();
      case (p)
        0: begin pulse_w = 16'd1;    clear_w = 16'd0;     end
        1: begin pulse_w = 16'd1023; clear_w = 16'hFFFF;  end
        2: begin pulse_w = 16'd0;    clear_w = 16'($urandom); end
        3: begin pulse_w = 16'd1000; clear_w = 16'($urandom); end
        default: begin
          // upper bits of the pulse write must be dropped by the 10-bit register
          pulse_w = 16'($urandom);
          clear_w = 16'($urandom);
        end
      endcase
      write_regs(pulse_w, clear_w);
      src_idle_pct = SRC_IDLE[p];
      snk_stall_pct = SNK_STALL[p];
      // last phase: receiver holds off while the sender keeps pushing
      if (p == NUM_PHASES - 1)
        hold_off_go = 1'b1;
      taken = 0;
      while (taken < ITEMS_PER_PHASE) begin
        req = pick_req();
        send_word(req, 8'($urandom_range(255)), 2'($urandom_range(3)),
                  5'($urandom_range(31)), 1'b1);
        if (req < REQ_RSVD_LO)
          taken++;
      end
    end

    // drain and let any stray event show up
    s_tvalid <= 1'b0;
    while (pin_event_q.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && pin_event_q.size() == 0)
      $display("tb_top: clean");
    else
      $display("tb_top: errors");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // receiver side: random stalls, plus one long hold-off counted here
  // ---------------------------------------------------------------------------

  initial begin
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_go) begin
        m_tready <= 1'b0;
        repeat (LONG_HOLD - 1) @(posedge clk);
        hold_off_go = 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= snk_stall_pct);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // output check: every taken event against the oldest owed one
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin : event_check
    pin_event_t want;
    pin_event_t got;
    if (!rst && m_tvalid && m_tready) begin
      got = {m_tuser, m_tdata[3:0], m_tdata[4], m_tdata[20:5], m_tlast};
      if (pin_event_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("event %0d: none owed, got rs=%0d nib=%h en=%0d hold=%0d last=%0d",
                   events_seen, got.rs, got.nib, got.en, got.hold, got.last);
      end else begin
        want = pin_event_q.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $write("event %0d: want rs=%0d nib=%h en=%0d hold=%0d last=%0d,",
                   events_seen, want.rs, want.nib, want.en, want.hold, want.last);
            $display(" got rs=%0d nib=%h en=%0d hold=%0d last=%0d",
                     got.rs, got.nib, got.en, got.hold, got.last);
          end
        end
      end
      events_seen++;
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog: too long with no word moving on either side
  // ---------------------------------------------------------------------------

  initial begin
    int quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
        quiet = 0;
      else
        quiet++;
    end
    $display("tb_top: errors");
    $finish;
  end

endmodule
